// ----- hdl/segment_sphere_hit_test_unit_macros.svh -----
// Assertion macros used by the segment and sphere hit test top level.
`ifndef SEGMENT_SPHERE_HIT_TEST_UNIT_MACROS_SVH
`define SEGMENT_SPHERE_HIT_TEST_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSHT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ssht_pkg.sv -----
// Shared constants and types for the segment and sphere hit test.
`default_nettype none

package ssht_pkg;

  // Default coordinate width: signed Q8.8.
  localparam int COORD_BITS = 16;

  // Stage enables handed to the split multiplier.
  typedef struct packed {
    logic pp_en;
    logic sum_en;
  } mul_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/ssht_req_if.sv -----
// Request channel carrying one segment and one sphere.
`default_nettype none

interface ssht_req_if #(
  parameter int COORD_BITS = ssht_pkg::COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic        [COORD_BITS-2:0] radius;

  modport source (
    output valid, start_x, start_y, start_z, end_x, end_y, end_z,
           center_x, center_y, center_z, radius,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
           center_x, center_y, center_z, radius,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/ssht_rsp_if.sv -----
// Response channel carrying the hit flag.
`default_nettype none

interface ssht_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/segment_sphere_hit_test_unit.sv -----
// Segment against sphere hit test: the top level and its six-stage pipeline.
//
// The block takes one request on req: segment start and end points and a
// sphere center, signed Q8.8, and a sphere radius, unsigned Q7.8. For every
// request it returns exactly one response on rsp, whose hit flag is 1 when
// a segment of nonzero length touches or crosses the sphere surface, in request order.
// Both channels use a valid and ready handshake.
// The decision is exact integer arithmetic: the quadratic along the segment
// and its quarter discriminant are formed at full width, no rounding.
// Throughput is one request per cycle while rsp is ready; each of the six
// register stages holds one request, and the squared terms of the
// discriminant are split into half-width partial products over two of them.
// A stage whose successor is stalled holds its request; empty stages still
// fill, so the block keeps taking requests while a response waits, until
// every stage holds one.
// Reset clears all stage valid bits; no response is pending after reset.
`default_nettype none

`include "segment_sphere_hit_test_unit_macros.svh"

module segment_sphere_hit_test_unit #(
  parameter int COORD_BITS = ssht_pkg::COORD_BITS
) (
  input  wire logic    clk,
  input  wire logic    rst,
  ssht_req_if.sink     req,
  ssht_rsp_if.source   rsp
);

  localparam int N      = COORD_BITS;
  localparam int DW     = N + 1;
  localparam int PW     = 2 * N + 2;
  localparam int RW     = N - 1;
  localparam int AW     = 2 * N + 4;
  localparam int FW     = 2 * N + 6;
  localparam int STAGES = 6;

  // Stage valid bits and the ready chain that lets bubbles close up.
  logic [STAGES:1] vld;
  logic [STAGES:1] rdy;

  always_comb begin
    rdy[STAGES] = !vld[STAGES] || rsp.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign req.ready = rdy[1];
  assign rsp.valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= req.valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: segment direction and start point relative to the center.
  logic signed [DW-1:0] d_x, d_y, d_z;
  logic signed [DW-1:0] v_x, v_y, v_z;
  logic        [RW-1:0] r1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      d_x <= DW'(req.end_x) - DW'(req.start_x);
      d_y <= DW'(req.end_y) - DW'(req.start_y);
      d_z <= DW'(req.end_z) - DW'(req.start_z);
      v_x <= DW'(req.start_x) - DW'(req.center_x);
      v_y <= DW'(req.start_y) - DW'(req.center_y);
      v_z <= DW'(req.start_z) - DW'(req.center_z);
      r1  <= req.radius;
    end
  end

  // Stage 2: the per-axis products and the squared radius.
  logic signed [PW-1:0]  dd_x, dd_y, dd_z;
  logic signed [PW-1:0]  dv_x, dv_y, dv_z;
  logic signed [PW-1:0]  vv_x, vv_y, vv_z;
  logic        [2*RW-1:0] rr;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dd_x <= d_x * d_x;
      dd_y <= d_y * d_y;
      dd_z <= d_z * d_z;
      dv_x <= d_x * v_x;
      dv_y <= d_y * v_y;
      dv_z <= d_z * v_z;
      vv_x <= v_x * v_x;
      vv_y <= v_y * v_y;
      vv_z <= v_z * v_z;
      rr   <= r1 * r1;
    end
  end

  // Stage 3: quadratic coefficients a, h (half of b) and c.
  logic signed [AW-1:0] a, h, c;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      a <= AW'(dd_x) + AW'(dd_y) + AW'(dd_z);
      h <= AW'(dv_x) + AW'(dv_y) + AW'(dv_z);
      c <= AW'(vv_x) + AW'(vv_y) + AW'(vv_z) - AW'($signed({1'b0, rr}));
    end
  end

  // Stage 4: endpoint and vertex conditions, folded into one flag.
  logic signed [FW-1:0] f1;
  logic signed [AW:0]   ah;
  logic                 a_nz, c_le, f1_le, some_ge, vertex_in;
  logic                 pre4, pre5;

  always_comb begin
    f1        = FW'(a) + FW'(h) + FW'(h) + FW'(c);
    ah        = (AW + 1)'(a) + (AW + 1)'(h);
    a_nz      = (a != '0);
    c_le      = c[AW-1] || (c == '0);
    f1_le     = f1[FW-1] || (f1 == '0);
    some_ge   = !c[AW-1] || !f1[FW-1];
    vertex_in = (h[AW-1] || (h == '0)) && !ah[AW];
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) pre4 <= a_nz && some_ge && (c_le || f1_le || vertex_in);
    if (rdy[5]) pre5 <= pre4;
  end

  // Stages 4 and 5: h*h and a*c through split multipliers.
  ssht_pkg::mul_ctl_t   mul_ctl;
  logic signed [2*AW-1:0] hh;
  logic signed [2*AW-1:0] ac;

  assign mul_ctl.pp_en  = rdy[4];
  assign mul_ctl.sum_en = rdy[5];

  ssht_split_mul #(.W(AW)) u_mul_hh (
    .clk  (clk),
    .ctl  (mul_ctl),
    .x    (h),
    .y    (h),
    .prod (hh)
  );

  ssht_split_mul #(.W(AW)) u_mul_ac (
    .clk  (clk),
    .ctl  (mul_ctl),
    .x    (a),
    .y    (c),
    .prod (ac)
  );

  // Stage 6: a hit needs a non-negative discriminant, h*h >= a*c.
  logic hit6;

  always_ff @(posedge clk) begin
    if (rdy[6]) hit6 <= pre5 && (hh >= ac);
  end

  assign rsp.hit = hit6;

  `SSHT_ASSERT_NEXT(a_accept_enters, clk, rst, req.valid && req.ready, vld[1], "accepted request lost at stage one")
  `SSHT_ASSERT_NEXT(a_stall_holds, clk, rst, vld[3] && !rdy[4], vld[3] && $stable(a) && $stable(h), "stalled stage three changed")
  `SSHT_ASSERT_NOW(a_empty_out_ready, clk, rst, !vld[STAGES], req.ready, "request refused with an empty output stage")
  `SSHT_ASSERT_NEXT(a_miss_gate, clk, rst, vld[5] && !pre5 && rdy[6], !hit6, "hit reported without endpoint or vertex condition")

endmodule

`default_nettype wire

// ----- hdl/ssht_split_mul.sv -----
// Two-stage signed multiplier built from half-width partial products.
`default_nettype none

module ssht_split_mul #(
  parameter int W = 36
) (
  input  wire logic               clk,
  input  wire ssht_pkg::mul_ctl_t ctl,
  input  wire logic signed [W-1:0] x,
  input  wire logic signed [W-1:0] y,
  output logic signed [2*W-1:0]    prod
);

  localparam int L = W / 2;
  localparam int H = W - L;

  // Operands split into a signed upper half and an unsigned lower half.
  logic signed [H-1:0] xh;
  logic signed [H-1:0] yh;
  logic signed [L:0]   xl;
  logic signed [L:0]   yl;

  assign xh = x[W-1:L];
  assign yh = y[W-1:L];
  assign xl = $signed({1'b0, x[L-1:0]});
  assign yl = $signed({1'b0, y[L-1:0]});

  // Partial products, one register stage.
  logic signed [2*H-1:0]   p_hh;
  logic signed [H+L:0]     p_hl;
  logic signed [H+L:0]     p_lh;
  logic signed [2*L+1:0]   p_ll;

  always_ff @(posedge clk) begin
    if (ctl.pp_en) begin
      p_hh <= xh * yh;
      p_hl <= xh * yl;
      p_lh <= yh * xl;
      p_ll <= xl * yl;
    end
  end

  // Shifted partial products are summed into the full product.
  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      prod <= ((2*W)'(p_hh) <<< (2*L))
            + (((2*W)'(p_hl) + (2*W)'(p_lh)) <<< L)
            + (2*W)'(p_ll);
    end
  end

endmodule

`default_nettype wire

// ----- test/ssht_hit_checker.sv -----
// Checker for the segment and sphere hit test: predicts each hit flag and compares responses.

module ssht_hit_checker (
  input  logic clk,
  input  logic rst,
  ssht_req_if  req,
  ssht_rsp_if  rsp,
  output int   errors,
  output int   pending
);

  localparam int CW = ssht_pkg::COORD_BITS;

  // Hit flags predicted for accepted requests, oldest first.
  logic hit_q[$];
  int   rsp_seen;

  // Exact hit decision on the quadratic a*t^2 + 2*h*t + c along the segment.
  function automatic logic predict_hit(
    input logic signed [CW-1:0] sx, sy, sz, ex, ey, ez, cx, cy, cz,
    input logic        [CW-2:0] rad
  );
    logic signed [127:0] dx, dy, dz, vx, vy, vz, rr;
    logic signed [127:0] a, h, c, f1, disc;
    logic                vertex_in;
    dx = $signed(ex) - $signed(sx);
    dy = $signed(ey) - $signed(sy);
    dz = $signed(ez) - $signed(sz);
    vx = $signed(sx) - $signed(cx);
    vy = $signed(sy) - $signed(cy);
    vz = $signed(sz) - $signed(cz);
    rr = $signed({1'b0, rad});
    a = dx * dx + dy * dy + dz * dz;
    h = dx * vx + dy * vy + dz * vz;
    c = vx * vx + vy * vy + vz * vz - rr * rr;
    f1 = a + h + h + c;
    disc = h * h - a * c;
    // The vertex of the parabola lies in [0,1] when 0 <= -h <= a.
    vertex_in = (h <= 0) && (a + h >= 0);
    return (a != 0) && (disc >= 0) && (c >= 0 || f1 >= 0) &&
           (c <= 0 || f1 <= 0 || vertex_in);
  endfunction

  // Prints one line per mismatch; past the first hundred it only counts.
  task automatic report_mismatch(input string what);
    if (errors < 100) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    errors <= errors + 1;
  endtask

  initial begin
    errors   = 0;
    pending  = 0;
    rsp_seen = 0;
  end

  // Compare each accepted response with the oldest prediction, then record new requests.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (hit_q.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with no request waiting", rsp_seen));
        end else begin
          if (rsp.hit !== hit_q[0]) begin
            report_mismatch($sformatf("response %0d: hit %b, predicted %b",
                                      rsp_seen, rsp.hit, hit_q[0]));
          end
          void'(hit_q.pop_front());
        end
        rsp_seen = rsp_seen + 1;
      end
      if (req.valid && req.ready) begin
        hit_q.push_back(predict_hit(req.start_x, req.start_y, req.start_z,
                                    req.end_x, req.end_y, req.end_z,
                                    req.center_x, req.center_y, req.center_z,
                                    req.radius));
      end
      pending <= hit_q.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the segment and sphere hit test: stimulus, response pacing and verdict.

module tb_top;

  localparam int CW = ssht_pkg::COORD_BITS;
  localparam int RW = CW - 1;
  localparam int RANDOM_PER_PHASE = 317;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   send_idle;
  int   rcv_idle;

  ssht_req_if req_ch ();
  ssht_rsp_if rsp_ch ();

  segment_sphere_hit_test_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ssht_hit_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Give up if the run stalls far beyond its slowest legal pace.
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  // Response side: drop ready at random with the current idle rate.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Uniform value in [-span, span].
  function automatic int rnd_span(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Offer one request after a random number of idle cycles, then wait for acceptance.
  task automatic send_req(input int sx, sy, sz, ex, ey, ez, cx, cy, cz, rad);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.start_x  <= CW'(sx);
    req_ch.start_y  <= CW'(sy);
    req_ch.start_z  <= CW'(sz);
    req_ch.end_x    <= CW'(ex);
    req_ch.end_y    <= CW'(ey);
    req_ch.end_z    <= CW'(ez);
    req_ch.center_x <= CW'(cx);
    req_ch.center_y <= CW'(cy);
    req_ch.center_z <= CW'(cz);
    req_ch.radius   <= RW'(rad);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Hold the request channel idle until every predicted response has come back.
  task automatic drain;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One random request: mostly shaped near a sphere, the rest raw bits.
  task automatic send_random;
    int s[3];
    int e[3];
    int k[3];
    int r;
    int kind;
    int ax;
    int px;
    kind = $urandom_range(99);
    r = $urandom_range(1, 4096);
    for (int i = 0; i < 3; i++) begin
      k[i] = rnd_span(16384);
      s[i] = k[i] + rnd_span(3 * r);
      e[i] = k[i] + rnd_span(3 * r);
    end
    if (kind < 25) begin
      // Raw random bits in every field.
      for (int i = 0; i < 3; i++) begin
        s[i] = int'($urandom());
        e[i] = int'($urandom());
        k[i] = int'($urandom());
      end
      r = int'($urandom());
    end else if (kind < 60) begin
      // Segment ends scattered around the sphere; kept as drawn above.
    end else if (kind < 75) begin
      // Line tangent to the sphere along one axis, offset by r on another.
      ax = $urandom_range(2);
      px = (ax + 1) % 3;
      for (int i = 0; i < 3; i++) begin
        s[i] = k[i];
        e[i] = k[i];
      end
      s[px] = ($urandom_range(1) != 0) ? k[px] + r : k[px] - r;
      e[px] = s[px];
      s[ax] = k[ax] + rnd_span(2 * r);
      e[ax] = k[ax] + rnd_span(2 * r);
    end else if (kind < 85) begin
      // Zero-length segment.
      for (int i = 0; i < 3; i++) e[i] = s[i];
    end else begin
      // Both ends strictly inside the sphere.
      for (int i = 0; i < 3; i++) begin
        s[i] = k[i] + rnd_span(r / 2);
        e[i] = k[i] + rnd_span(r / 2);
      end
    end
    send_req(s[0], s[1], s[2], e[0], e[1], e[2], k[0], k[1], k[2], r);
  endtask

  // Main sequence: reset, directed cases, then three paced random phases.
  initial begin
    rst             = 1'b1;
    send_idle       = 19;
    rcv_idle        = 79;
    req_ch.valid    = 1'b0;
    req_ch.start_x  = '0;
    req_ch.start_y  = '0;
    req_ch.start_z  = '0;
    req_ch.end_x    = '0;
    req_ch.end_y    = '0;
    req_ch.end_z    = '0;
    req_ch.center_x = '0;
    req_ch.center_y = '0;
    req_ch.center_z = '0;
    req_ch.radius   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes of the fields and the named special cases.
    send_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_req(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 32767);
    send_req(32767, 32767, 32767, -32768, -32768, -32768, -32768, -32768, -32768, 0);
    send_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0);
    send_req(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
    // Zero radius, segment through the center.
    send_req(-256, 0, 0, 256, 0, 0, 0, 0, 0, 0);
    // Tangent contact inside the segment, and tangent point before its start.
    send_req(-512, 256, 0, 512, 256, 0, 0, 0, 0, 256);
    send_req(512, 256, 0, 1024, 256, 0, 0, 0, 0, 256);
    // Negative discriminant.
    send_req(-512, 512, 0, 512, 512, 0, 0, 0, 0, 256);
    // Both ends strictly inside.
    send_req(-10, 0, 0, 10, 0, 0, 0, 0, 0, 256);
    // Crossing from inside to outside and from outside to inside.
    send_req(0, 0, 0, 1024, 0, 0, 0, 0, 0, 256);
    send_req(0, 0, -1024, 0, 0, 0, 0, 0, 0, 256);
    // Line hits, but only behind the start point.
    send_req(1024, 0, 0, 2048, 0, 0, 0, 0, 0, 256);
    // Start point exactly on the surface, and end point exactly on it.
    send_req(256, 0, 0, 1024, 0, 0, 0, 0, 0, 256);
    send_req(1024, 0, 0, 256, 0, 0, 0, 0, 0, 256);
    // Both ends outside, closest point within the segment.
    send_req(-1024, 0, 0, 1024, 0, 0, 0, 0, 0, 256);
    send_req(-1024, 100, 50, 1024, -100, -50, 0, 0, 0, 256);
    // Zero-length segment inside and on the surface.
    send_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 256);
    send_req(0, 256, 0, 0, 256, 0, 0, 0, 0, 256);
    // Off-origin sphere with negative coordinates.
    send_req(-4096, -3000, -2000, -1000, -3000, -2000, -2500, -3000, -2000, 300);

    // Let the pipeline empty completely before random traffic.
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 19;
          rcv_idle  = 79;
        end
        1: begin
          send_idle = 79;
          rcv_idle  = 19;
        end
        default: begin
          send_idle = 0;
          rcv_idle  = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random();
    end

    // Wait out every response, then a few cycles for any stray one.
    send_idle = 0;
    rcv_idle  = 0;
    drain();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- segment_sphere_hit_test_unit.f -----
+incdir+hdl
hdl/ssht_pkg.sv
hdl/ssht_req_if.sv
hdl/ssht_rsp_if.sv
hdl/ssht_split_mul.sv
hdl/segment_sphere_hit_test_unit.sv
test/ssht_hit_checker.sv
test/tb_top.sv
